// ===== sv/ghba_pkg.sv =====
// ----------------------------------------------------------------------------
// ghba_pkg
// Shared types and constants of the Gaussian hill bias accumulator: register
// indexes, fixed-point limits and the structs that link the datapath units.
// ----------------------------------------------------------------------------
package ghba_pkg;

	// Number of coordinate fields carried by an item and stored per hill.
	localparam int COORD_FIELDS = 4;
	// Largest number of variables the bias is built over.
	localparam int NUM_DIMS = 4;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_ACTIVE_DIMS  = 3'd0;
	localparam logic [2:0] REG_INV_WIDTH_0  = 3'd1;
	localparam logic [2:0] REG_INV_WIDTH_1  = 3'd2;
	localparam logic [2:0] REG_INV_WIDTH_2  = 3'd3;
	localparam logic [2:0] REG_INV_WIDTH_3  = 3'd4;
	localparam logic [2:0] REG_BASE_HEIGHT  = 3'd5;
	localparam logic [2:0] REG_DEPOSIT_PACE = 3'd6;
	localparam logic [2:0] REG_TEMPER_SCALE = 3'd7;

	// Cutoff on the Q11.32 sum of squared scaled distances (12.5).
	localparam logic [42:0] CUT_SUMSQ = 43'd53687091200;
	// Clamp on one scaled distance magnitude.
	localparam logic [20:0] MAG_LIMIT = 21'h100000;
	// The exp argument spans [0,8) per table sweep: the low 19 bits of its Q6.16 value.
	localparam int SPAN_BITS = 19;
	// Width of the exp argument; a tempering argument of 32 or more is held at 32.
	localparam int EXP_X_W = 22;
	// Register stages from an exp request to its response.
	localparam int EXP_LAT = 8;

	// Configuration register file contents.
	typedef struct packed {
		logic [2:0]                         active_dims;
		logic [COORD_FIELDS-1:0][23:0]      inv_width;
		logic [23:0]                        base_height;
		logic [15:0]                        deposit_pace;
		logic [23:0]                        temper_scale;
	} cfg_t;

	// One stored hill.
	typedef struct packed {
		logic [23:0]                        height;
		logic [COORD_FIELDS-1:0][31:0]      centre;
	} hill_t;

	// Request to the exp unit: weight height by exp(-x).
	typedef struct packed {
		logic                               valid;
		logic                               tag;
		logic [EXP_X_W-1:0]                 x;
		logic [23:0]                        height;
	} exp_req_t;

	// Response of the exp unit.
	typedef struct packed {
		logic                               valid;
		logic                               tag;
		logic [23:0]                        hb;
	} exp_rsp_t;

endpackage

// ===== sv/ghba_if.sv =====
// ----------------------------------------------------------------------------
// ghba_if
// Valid/ready channels of the hill bias accumulator: the step item channel
// and the result channel.
// ----------------------------------------------------------------------------

// Step item: step number and four coordinates.
interface ghba_item_if;
	logic               valid;
	logic               ready;
	logic [31:0]        step_number;
	logic signed [31:0] coord_0;
	logic signed [31:0] coord_1;
	logic signed [31:0] coord_2;
	logic signed [31:0] coord_3;

	modport source (output valid, step_number, coord_0, coord_1, coord_2, coord_3,
		input ready);
	modport sink (input valid, step_number, coord_0, coord_1, coord_2, coord_3,
		output ready);
endinterface

// Result: bias, forces and deposition status.
interface ghba_result_if;
	logic               valid;
	logic               ready;
	logic [31:0]        bias_energy;
	logic signed [31:0] push_0;
	logic signed [31:0] push_1;
	logic signed [31:0] push_2;
	logic signed [31:0] push_3;
	logic               hill_deposited;
	logic               store_full;
	logic [23:0]        deposited_height;
	logic [10:0]        hills_held;

	modport source (output valid, bias_energy, push_0, push_1, push_2, push_3,
		hill_deposited, store_full, deposited_height, hills_held, input ready);
	modport sink (input valid, bias_energy, push_0, push_1, push_2, push_3,
		hill_deposited, store_full, deposited_height, hills_held, output ready);
endinterface

// ===== sv/gaussian_hill_bias_accumulator.sv =====
// Sequence: a step walks all stored hills while the step-number remainder is
// reckoned; a deposit adds the tempering pass through the exp unit.
// Throughput: one step at a time; the hill store is read one hill per cycle,
// and the next item is taken only after the result register is loaded.
// Reset: the hill count and control registers are cleared at once; the store contents
// are left as they are and never read before being written.
// ----------------------------------------------------------------------------
// gaussian_hill_bias_accumulator
// Sums Gaussian hills from the hill store at the input coordinates, gives
// the bias and forces, and deposits a new (optionally tempered) hill if due and not full.
// ----------------------------------------------------------------------------
module gaussian_hill_bias_accumulator import ghba_pkg::*; #(
	parameter int MAX_HILLS       = 1024,
	parameter int EXP_TABLE_DEPTH = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [4:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	ghba_item_if.sink            items,
	ghba_result_if.source        results
);

	localparam int HAW     = (MAX_HILLS > 1) ? $clog2(MAX_HILLS) : 1;
	localparam int HCW     = $clog2(MAX_HILLS + 1);
	localparam int BIAS_W  = 24 + HCW;
	localparam int FORCE_W = 38 + HCW;

	typedef enum logic [2:0] {
		IDLE, WALK, TEMPER_MUL, TEMPER_ISSUE, TEMPER_WAIT, FINISH
	} state_t;

	cfg_t      cfg;
	state_t    state_q;
	logic [HCW-1:0] h_q, total_q;
	logic      accept, issue, any_valid, out_free, mem_we;
	logic      mod_done, mod_due, exp_busy, full_now;
	hill_t     rd_hill, wr_hill;
	exp_req_t  exp_req;
	exp_rsp_t  exp_rsp;
	logic [2:0] dims;

	// Item registers.
	logic signed [31:0] coord_q [COORD_FIELDS];
	logic [2:0]       dims_q;

	// Hill pipeline.
	logic             v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_f1, v_f2;
	logic [32:0]      ad_s1 [COORD_FIELDS];
	logic             neg_s1 [COORD_FIELDS];
	logic [32:0]      ad_s2 [COORD_FIELDS];
	logic             neg_s2 [COORD_FIELDS], neg_s3 [COORD_FIELDS];
	logic             neg_s4 [COORD_FIELDS], neg_s5 [COORD_FIELDS];
	logic             neg_s6 [COORD_FIELDS];
	logic [23:0]      h_s2, h_s3, h_s4, h_s5, h_s6;
	logic [40:0]      ph_s3 [COORD_FIELDS];
	logic [39:0]      pl_s3 [COORD_FIELDS];
	logic [41:0]      m_s3 [COORD_FIELDS];
	logic [20:0]      mag_s4 [COORD_FIELDS], mag_s5 [COORD_FIELDS], mag_s6 [COORD_FIELDS];
	logic [40:0]      sq_s5 [COORD_FIELDS];
	logic [42:0]      sum_s6;
	logic [20:0]      mag_dl [EXP_LAT][COORD_FIELDS];
	logic             neg_dl [EXP_LAT][COORD_FIELDS];
	logic [44:0]      hm [COORD_FIELDS];
	logic [28:0]      p1_f1 [COORD_FIELDS];
	logic             neg_f1 [COORD_FIELDS], neg_f2 [COORD_FIELDS];
	logic [52:0]      tw [COORD_FIELDS];
	logic [36:0]      t_f2 [COORD_FIELDS];
	logic [BIAS_W-1:0]  bias_q;
	logic signed [FORCE_W-1:0] force_q [COORD_FIELDS];

	// Deposit and result registers.
	logic [31:0]      bias_sat, bias_out_q;
	logic [55:0]      arg_prod;
	logic [39:0]      arg_q;
	logic             dep_q, full_q;
	logic [23:0]      dep_h_q;
	logic [31:0]      push_sat [COORD_FIELDS];
	logic [31:0]      res_bias_q;
	logic [31:0]      res_push_q [COORD_FIELDS];
	logic             res_v_q, res_dep_q, res_full_q;
	logic [23:0]      res_dh_q;
	logic [10:0]      res_held_q;

	ghba_apb_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg
	);

	ghba_hill_mem #(.DEPTH(MAX_HILLS), .AW(HAW)) u_mem (
		.clk,
		.we    (mem_we),
		.waddr (total_q[HAW-1:0]),
		.wdata (wr_hill),
		.re    (issue),
		.raddr (h_q[HAW-1:0]),
		.rdata (rd_hill)
	);

	ghba_exp_unit #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_exp (
		.clk, .arst_n, .req(exp_req), .rsp(exp_rsp), .busy(exp_busy)
	);

	ghba_step_mod u_mod (
		.clk, .arst_n,
		.start (accept),
		.step  (items.step_number),
		.pace  (cfg.deposit_pace),
		.done  (mod_done),
		.due   (mod_due)
	);

	// Handshake and walk control.
	assign accept    = items.valid && items.ready;
	assign items.ready = state_q == IDLE;
	assign issue     = (state_q == WALK) && (h_q < total_q);
	assign any_valid = v_s1 | v_s2 | v_s3 | v_s4 | v_s5 | v_s6 | exp_busy | v_f1 | v_f2;
	assign out_free  = !res_v_q || results.ready;
	assign mem_we    = (state_q == FINISH) && out_free && dep_q;
	assign full_now  = total_q == HCW'(MAX_HILLS);

	// Variables in use: limited by the coordinate fields and the dimension cap.
	always_comb begin
		dims = cfg.active_dims;
		if (dims > 3'(COORD_FIELDS)) begin
			dims = 3'(COORD_FIELDS);
		end
		if (dims > 3'(NUM_DIMS)) begin
			dims = 3'(NUM_DIMS);
		end
	end

	// New hill record.
	always_comb begin
		wr_hill.height = dep_h_q;
		for (int i = 0; i < COORD_FIELDS; i++) begin
			wr_hill.centre[i] = coord_q[i];
		end
	end

	// Signed distance to the hill centre, as magnitude and sign, and combinational terms of later stages.
	always_comb begin
		for (int i = 0; i < COORD_FIELDS; i++) begin
			logic signed [32:0] d;
			d = 33'(coord_q[i]) - 33'(signed'(rd_hill.centre[i]));
			neg_s1[i] = d[32];
			ad_s1[i]  = d[32] ? 33'(-d) : 33'(d);
			m_s3[i]   = 42'(ph_s3[i]) + 42'(pl_s3[i][39:16]);
			hm[i]     = 45'(exp_rsp.hb) * 45'(mag_dl[EXP_LAT-1][i]);
			tw[i]     = 53'(p1_f1[i]) * 53'(cfg.inv_width[i]);
		end
	end

	// Exp requests: hill weights while walking, the tempering factor after.
	always_comb begin
		if (state_q == TEMPER_ISSUE) begin
			exp_req.valid  = 1'b1;
			exp_req.tag    = 1'b1;
			exp_req.x      = (|arg_q[39:21]) ? EXP_X_W'(22'h200000) : EXP_X_W'(arg_q[20:0]);
			exp_req.height = cfg.base_height;
		end else begin
			exp_req.valid  = v_s6;
			exp_req.tag    = 1'b0;
			exp_req.x      = sum_s6[38:17];
			exp_req.height = (sum_s6 < CUT_SUMSQ) ? h_s6 : 24'd0;
		end
	end

	// Pipeline valid chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_f1, v_f2} <= '0;
		end else begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= {issue, v_s1, v_s2, v_s3, v_s4, v_s5};
			v_f1 <= exp_rsp.valid && !exp_rsp.tag;
			v_f2 <= v_f1;
		end
	end

	// Hill pipeline: scaled distances, squares, sum, then force terms.
	always_ff @(posedge clk) begin
		h_s2 <= rd_hill.height;
		h_s3 <= h_s2;
		h_s4 <= h_s3;
		h_s5 <= h_s4;
		h_s6 <= h_s5;
		sum_s6 <= 43'(sq_s5[0]) + 43'(sq_s5[1]) + 43'(sq_s5[2]) + 43'(sq_s5[3]);
		for (int i = 0; i < COORD_FIELDS; i++) begin
			ad_s2[i]  <= ad_s1[i];
			neg_s2[i] <= neg_s1[i];
			ph_s3[i]  <= 41'(ad_s2[i][32:16]) * 41'(cfg.inv_width[i]);
			pl_s3[i]  <= 40'(ad_s2[i][15:0]) * 40'(cfg.inv_width[i]);
			neg_s3[i] <= neg_s2[i];
			if (3'(i) >= dims_q) begin
				mag_s4[i] <= 21'd0;
			end else if (m_s3[i] > 42'(MAG_LIMIT)) begin
				mag_s4[i] <= MAG_LIMIT;
			end else begin
				mag_s4[i] <= m_s3[i][20:0];
			end
			neg_s4[i] <= neg_s3[i];
			sq_s5[i]  <= 41'(mag_s4[i]) * 41'(mag_s4[i]);
			mag_s5[i] <= mag_s4[i];
			neg_s5[i] <= neg_s4[i];
			mag_s6[i] <= mag_s5[i];
			neg_s6[i] <= neg_s5[i];
			// Align distances with the exp unit.
			mag_dl[0][i] <= mag_s6[i];
			neg_dl[0][i] <= neg_s6[i];
			for (int k = 1; k < EXP_LAT; k++) begin
				mag_dl[k][i] <= mag_dl[k-1][i];
				neg_dl[k][i] <= neg_dl[k-1][i];
			end
			// Force term: bias times distance, times inverse width.
			p1_f1[i]  <= hm[i][44:16];
			neg_f1[i] <= neg_dl[EXP_LAT-1][i];
			t_f2[i]   <= tw[i][52:16];
			neg_f2[i] <= neg_f1[i];
		end
	end

	// Accumulators, cleared when an item is taken.
	always_ff @(posedge clk) begin
		if (accept) begin
			bias_q <= '0;
			for (int i = 0; i < COORD_FIELDS; i++) begin
				force_q[i] <= '0;
			end
		end else begin
			if (exp_rsp.valid && !exp_rsp.tag) begin
				bias_q <= bias_q + BIAS_W'(exp_rsp.hb);
			end
			if (v_f2) begin
				for (int i = 0; i < COORD_FIELDS; i++) begin
					if (neg_f2[i]) begin
						force_q[i] <= force_q[i] - FORCE_W'(t_f2[i]);
					end else begin
						force_q[i] <= force_q[i] + FORCE_W'(t_f2[i]);
					end
				end
			end
		end
	end

	// Saturation of bias and forces.
	always_comb begin
		bias_sat = (|bias_q[BIAS_W-1:32]) ? 32'hFFFF_FFFF : bias_q[31:0];
		for (int i = 0; i < COORD_FIELDS; i++) begin
			if ((&force_q[i][FORCE_W-1:31]) || !(|force_q[i][FORCE_W-1:31])) begin
				push_sat[i] = force_q[i][31:0];
			end else if (force_q[i][FORCE_W-1]) begin
				push_sat[i] = 32'h8000_0000;
			end else begin
				push_sat[i] = 32'h7FFF_FFFF;
			end
		end
	end

	assign arg_prod = 56'(bias_out_q) * 56'(cfg.temper_scale);

	// Step sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			h_q     <= '0;
			total_q <= '0;
			res_v_q <= 1'b0;
			dep_q   <= 1'b0;
			full_q  <= 1'b0;
		end else begin
			// The result register empties on a transfer unless refilled this cycle.
			if (results.valid && results.ready && !(state_q == FINISH && out_free)) begin
				res_v_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						h_q     <= '0;
						coord_q[0] <= items.coord_0;
						coord_q[1] <= items.coord_1;
						coord_q[2] <= items.coord_2;
						coord_q[3] <= items.coord_3;
						dims_q  <= dims;
						state_q <= WALK;
					end
				end
				WALK: begin
					if (issue) begin
						h_q <= h_q + 1'b1;
					end else if (!any_valid && mod_done) begin
						bias_out_q <= bias_sat;
						dep_q      <= mod_due && !full_now;
						full_q     <= mod_due && full_now;
						dep_h_q    <= 24'd0;
						state_q    <= (mod_due && !full_now) ? TEMPER_MUL : FINISH;
					end
				end
				TEMPER_MUL: begin
					arg_q   <= arg_prod[55:16];
					state_q <= TEMPER_ISSUE;
				end
				TEMPER_ISSUE: begin
					state_q <= TEMPER_WAIT;
				end
				TEMPER_WAIT: begin
					if (exp_rsp.valid && exp_rsp.tag) begin
						dep_h_q <= exp_rsp.hb;
						state_q <= FINISH;
					end
				end
				FINISH: begin
					if (out_free) begin
						res_v_q    <= 1'b1;
						res_bias_q <= bias_out_q;
						for (int i = 0; i < COORD_FIELDS; i++) begin
							res_push_q[i] <= push_sat[i];
						end
						res_dep_q  <= dep_q;
						res_full_q <= full_q;
						res_dh_q   <= dep_h_q;
						res_held_q <= 11'(dep_q ? total_q + 1'b1 : total_q);
						if (dep_q) begin
							total_q <= total_q + 1'b1;
						end
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign results.valid            = res_v_q;
	assign results.bias_energy      = res_bias_q;
	assign results.push_0           = res_push_q[0];
	assign results.push_1           = res_push_q[1];
	assign results.push_2           = res_push_q[2];
	assign results.push_3           = res_push_q[3];
	assign results.hill_deposited   = res_dep_q;
	assign results.store_full       = res_full_q;
	assign results.deposited_height = res_dh_q;
	assign results.hills_held       = res_held_q;

`ifndef SYNTH
	// The hill count never passes the store depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= HCW'(MAX_HILLS))
		else $error("hill count beyond store depth");

	// A hill is written only when no read of the store is in flight.
	a_write_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !any_valid)
		else $error("store write during walk");

	// A new item is taken only with the pipeline empty.
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !any_valid && mod_done)
		else $error("item taken while busy");

	// A deposit grows the count by one at the next edge.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> total_q == $past(total_q) + 1'b1)
		else $error("hill count not advanced");
`endif

endmodule

// ===== sv/ghba_apb_regs.sv =====
// ----------------------------------------------------------------------------
// ghba_apb_regs
// Configuration register file behind an APB-style port. A write lands on
// the access cycle; pready is always high.
// ----------------------------------------------------------------------------
module ghba_apb_regs import ghba_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic [2:0] reg_idx;
	logic       wr_en;
	cfg_t       cfg_q;

	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// Register writes on a completed write transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_dims  <= 3'd1;
			cfg_q.inv_width    <= {COORD_FIELDS{24'd65536}};
			cfg_q.base_height  <= 24'd65536;
			cfg_q.deposit_pace <= 16'd500;
			cfg_q.temper_scale <= 24'd0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ACTIVE_DIMS:  cfg_q.active_dims  <= pwdata[2:0];
				REG_INV_WIDTH_0:  cfg_q.inv_width[0] <= pwdata[23:0];
				REG_INV_WIDTH_1:  cfg_q.inv_width[1] <= pwdata[23:0];
				REG_INV_WIDTH_2:  cfg_q.inv_width[2] <= pwdata[23:0];
				REG_INV_WIDTH_3:  cfg_q.inv_width[3] <= pwdata[23:0];
				REG_BASE_HEIGHT:  cfg_q.base_height  <= pwdata[23:0];
				REG_DEPOSIT_PACE: cfg_q.deposit_pace <= pwdata[15:0];
				REG_TEMPER_SCALE: cfg_q.temper_scale <= pwdata[23:0];
				default:          cfg_q.active_dims  <= cfg_q.active_dims;
			endcase
		end
	end

	// Read data.
	always_comb begin
		unique case (reg_idx)
			REG_ACTIVE_DIMS:  prdata = {29'd0, cfg_q.active_dims};
			REG_INV_WIDTH_0:  prdata = {8'd0, cfg_q.inv_width[0]};
			REG_INV_WIDTH_1:  prdata = {8'd0, cfg_q.inv_width[1]};
			REG_INV_WIDTH_2:  prdata = {8'd0, cfg_q.inv_width[2]};
			REG_INV_WIDTH_3:  prdata = {8'd0, cfg_q.inv_width[3]};
			REG_BASE_HEIGHT:  prdata = {8'd0, cfg_q.base_height};
			REG_DEPOSIT_PACE: prdata = {16'd0, cfg_q.deposit_pace};
			REG_TEMPER_SCALE: prdata = {8'd0, cfg_q.temper_scale};
			default:          prdata = 32'd0;
		endcase
	end

endmodule

// ===== sv/ghba_hill_mem.sv =====
// ----------------------------------------------------------------------------
// ghba_hill_mem
// Hill store: one write port and one read port, read data registered.
// Contents are not cleared; only entries below the hill count are read.
// ----------------------------------------------------------------------------
module ghba_hill_mem import ghba_pkg::*; #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  hill_t         wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output hill_t         rdata
);

	hill_t mem [DEPTH];
	hill_t rdata_q;

	assign rdata = rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

// ===== sv/ghba_exp_unit.sv =====
// ----------------------------------------------------------------------------
// ghba_exp_unit
// Pipelined height*exp(-x): table lookup with linear interpolation over
// [0,8), up to three further factors of exp(-8), then the height product.
// Eight stages, one request per cycle.
// ----------------------------------------------------------------------------
module ghba_exp_unit import ghba_pkg::*; #(
	parameter int EXP_TABLE_DEPTH = 256
) (
	input  logic     clk,
	input  logic     arst_n,
	input  exp_req_t req,
	output exp_rsp_t rsp,
	output logic     busy
);

	localparam int TAB_AW = $clog2(EXP_TABLE_DEPTH + 1);
	localparam int POS_W  = SPAN_BITS + TAB_AW;
	localparam logic [63:0] SPAN_STEP = (64'd1 << 35) / EXP_TABLE_DEPTH;

	typedef logic [32:0] exp_tab_t [0:EXP_TABLE_DEPTH];

	// exp(-8/DEPTH) by a truncated series, then its powers, Q1.32.
	function automatic exp_tab_t build_exp_tab();
		exp_tab_t     t;
		logic [127:0] term;
		logic [127:0] r;
		term = 128'd1 << 32;
		r    = 128'd1 << 32;
		for (int k = 1; k <= 12; k++) begin
			term = ((term * 128'(SPAN_STEP)) >> 32) / 128'(k);
			if ((k & 1) == 1) begin
				r = r - term;
			end else begin
				r = r + term;
			end
		end
		t[0] = 33'h1_0000_0000;
		for (int i = 1; i <= EXP_TABLE_DEPTH; i++) begin
			t[i] = 33'(((128'(t[i-1]) * r) + 128'h8000_0000) >> 32);
		end
		return t;
	endfunction

	localparam exp_tab_t    EXP_TAB  = build_exp_tab();
	localparam logic [31:0] EXP_SPAN = EXP_TAB[EXP_TABLE_DEPTH][31:0];

	// One factor of exp(-8) when the span count passes this stage.
	function automatic logic [32:0] scale_step(input logic [32:0] v,
		input logic [2:0] n, input logic [2:0] k);
		logic [64:0] p;
		p = 65'(v) * 65'(EXP_SPAN);
		if (n > k) begin
			return p[64:32];
		end
		return v;
	endfunction

	logic                 v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic                 tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7, tag_s8;
	logic [2:0]           n_s1, n_s2, n_s3, n_s4, n_s5, n_s6;
	logic [23:0]          h_s1, h_s2, h_s3, h_s4, h_s5, h_s6, h_s7;
	logic [POS_W-1:0]     pos_s1;
	logic [32:0]          t0_s2, t1_s2, t0_s3;
	logic [SPAN_BITS-1:0] frac_s2;
	logic [50:0]          dp_s3;
	logic [32:0]          e_s4, e_s5, e_s6, e_s7;
	logic [23:0]          hb_s8;
	logic [TAB_AW-1:0]    idx;
	logic [32:0]          diff;
	logic [56:0]          hprod;

	assign idx   = pos_s1[POS_W-1:SPAN_BITS];
	assign diff  = t0_s2 - t1_s2;
	assign hprod = 57'(h_s7) * 57'(e_s7);

	// Valid and tag chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <= '0;
		end else begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <=
				{req.valid, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7};
		end
	end

	// Datapath stages.
	always_ff @(posedge clk) begin
		// Table position of the argument within its span.
		pos_s1 <= POS_W'(req.x[SPAN_BITS-1:0]) * POS_W'(EXP_TABLE_DEPTH);
		n_s1   <= req.x[EXP_X_W-1:SPAN_BITS];
		h_s1   <= req.height;
		tag_s1 <= req.tag;
		// Neighboring table entries.
		t0_s2   <= EXP_TAB[idx];
		t1_s2   <= EXP_TAB[TAB_AW'(idx + 1'b1)];
		frac_s2 <= pos_s1[SPAN_BITS-1:0];
		n_s2    <= n_s1;
		h_s2    <= h_s1;
		tag_s2  <= tag_s1;
		// Interpolation product.
		dp_s3  <= 51'(diff[31:0]) * 51'(frac_s2);
		t0_s3  <= t0_s2;
		n_s3   <= n_s2;
		h_s3   <= h_s2;
		tag_s3 <= tag_s2;
		// Interpolated value; four spans or more underflow to zero.
		e_s4   <= n_s3[2] ? 33'd0 : t0_s3 - 33'(dp_s3[50:SPAN_BITS]);
		n_s4   <= n_s3;
		h_s4   <= h_s3;
		tag_s4 <= tag_s3;
		// Whole spans of exp(-8).
		e_s5   <= scale_step(e_s4, n_s4, 3'd0);
		n_s5   <= n_s4;
		h_s5   <= h_s4;
		tag_s5 <= tag_s4;
		e_s6   <= scale_step(e_s5, n_s5, 3'd1);
		n_s6   <= n_s5;
		h_s6   <= h_s5;
		tag_s6 <= tag_s5;
		e_s7   <= scale_step(e_s6, n_s6, 3'd2);
		h_s7   <= h_s6;
		tag_s7 <= tag_s6;
		// Height times exp.
		hb_s8  <= hprod[55:32];
		tag_s8 <= tag_s7;
	end

	assign rsp.valid = v_s8;
	assign rsp.tag   = tag_s8;
	assign rsp.hb    = hb_s8;
	assign busy      = v_s1 | v_s2 | v_s3 | v_s4 | v_s5 | v_s6 | v_s7 | v_s8;

endmodule

// ===== sv/ghba_step_mod.sv =====
// ----------------------------------------------------------------------------
// ghba_step_mod
// Remainder of the step number by the deposit pace, one bit per cycle,
// and the resulting deposit-due flag.
// ----------------------------------------------------------------------------
module ghba_step_mod (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] step,
	input  logic [15:0] pace,
	output logic        done,
	output logic        due
);

	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [31:0] dvd_q;
	logic [15:0] rem_q;
	logic [15:0] pace_q;
	logic [16:0] trial;

	assign trial = {rem_q, dvd_q[31]};
	assign done  = !busy_q;
	assign due   = (pace_q != 16'd0) && (rem_q == 16'd0);

	// Control: bit counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd32;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 6'd1;
			busy_q <= cnt_q != 6'd1;
		end
	end

	// Restoring remainder step.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q  <= step;
			rem_q  <= 16'd0;
			pace_q <= pace;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			if (trial >= {1'b0, pace_q}) begin
				rem_q <= 16'(trial - {1'b0, pace_q});
			end else begin
				rem_q <= trial[15:0];
			end
		end
	end

endmodule
